[sv/mpct_pkg.sv]
// Shared types, constants and helpers for the MP configuration table parser.
`default_nettype none

package mpct_pkg;

   // Input item: one table byte and its start-of-table mark
   typedef struct packed {
      logic [7:0] data_byte;
      logic       first;
   } req_type;

   // Result item: processor report or final status
   typedef struct packed {
      logic       is_done;
      logic [7:0] apic_id;
      logic [2:0] status;
      logic [7:0] cpu_count;
   } rsp_type;

   // Status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_SIG  = 3'd1;
   localparam logic [2:0] ST_SHORT    = 3'd2;
   localparam logic [2:0] ST_BASE_SUM = 3'd3;
   localparam logic [2:0] ST_EXT_SUM  = 3'd4;

   // Parse phase codes
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_BASE = 2'd1;
   localparam logic [1:0] PH_EXT  = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   // Header layout, byte offsets
   localparam logic [16:0] OFF_SIG_END  = 17'd4;
   localparam logic [16:0] OFF_BASE_LO  = 17'd4;
   localparam logic [16:0] OFF_BASE_HI  = 17'd5;
   localparam logic [16:0] OFF_CNT_LO   = 17'd34;
   localparam logic [16:0] OFF_CNT_HI   = 17'd35;
   localparam logic [16:0] OFF_EXT_LO   = 17'd40;
   localparam logic [16:0] OFF_EXT_HI   = 17'd41;
   localparam logic [16:0] HDR_LAST     = 17'd43;
   localparam logic [16:0] HDR_BYTES    = 17'd44;
   localparam logic [15:0] HDR_LEN_MIN  = 16'd44;

   // Entry sizes
   localparam logic [4:0] PROC_ENTRY_BYTES  = 5'd20;
   localparam logic [4:0] OTHER_ENTRY_BYTES = 5'd8;
   localparam logic [7:0] KIND_PROC         = 8'd0;

   localparam logic [7:0] CPU_COUNT_MAX = 8'd255;

   // Signature "PCMP", one byte per offset
   function automatic logic [7:0] sig_byte(input logic [1:0] idx);
      logic [7:0] b;
      unique case (idx)
         2'd0:    b = 8'h50;
         2'd1:    b = 8'h43;
         2'd2:    b = 8'h4D;
         default: b = 8'h50;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

[sv/mpct_parse.sv]
// Parse state and per-byte update logic of the MP configuration table parser.
`default_nettype none

module mpct_parse
   import mpct_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire req_type item,
   output logic         res_valid,
   output rsp_type      res
);

   logic [1:0]  phase_ff,    phase_in;
   logic [16:0] offset_ff,   offset_in;
   logic [7:0]  sum_ff,      sum_in;
   logic [15:0] base_len_ff, base_len_in;
   logic [15:0] ent_decl_ff, ent_decl_in;
   logic [15:0] ext_len_ff,  ext_len_in;
   logic [15:0] ent_seen_ff, ent_seen_in;
   logic [4:0]  ent_pos_ff,  ent_pos_in;
   logic [7:0]  ent_kind_ff, ent_kind_in;
   logic [7:0]  cpu_cnt_ff,  cpu_cnt_in;

   // Compute next state and the result for one byte
   always_comb begin
      logic        active;
      logic [1:0]  phase_c;
      logic [16:0] off_c;
      logic [7:0]  sum_c, sum_new, b, kind_c;
      logic [15:0] base_c, decl_c, ext_c, seen_c;
      logic [4:0]  pos_c, pos_next, size_c;
      logic [7:0]  cpu_c;
      logic        fin, report;
      logic [2:0]  fin_st;
      logic [7:0]  rep_id;

      phase_in    = phase_ff;
      offset_in   = offset_ff;
      sum_in      = sum_ff;
      base_len_in = base_len_ff;
      ent_decl_in = ent_decl_ff;
      ext_len_in  = ext_len_ff;
      ent_seen_in = ent_seen_ff;
      ent_pos_in  = ent_pos_ff;
      ent_kind_in = ent_kind_ff;
      cpu_cnt_in  = cpu_cnt_ff;
      res_valid   = 1'b0;
      res         = '0;
      fin         = 1'b0;
      fin_st      = ST_OK;
      report      = 1'b0;
      rep_id      = '0;
      b           = item.data_byte;
      pos_next    = '0;
      size_c      = OTHER_ENTRY_BYTES;
      sum_new     = '0;

      // A first byte restarts from a cleared parse
      if (item.first) begin
         phase_c = PH_BASE;
         off_c   = '0;
         sum_c   = '0;
         base_c  = '0;
         decl_c  = '0;
         ext_c   = '0;
         seen_c  = '0;
         pos_c   = '0;
         kind_c  = '0;
         cpu_c   = '0;
      end else begin
         phase_c = phase_ff;
         off_c   = offset_ff;
         sum_c   = sum_ff;
         base_c  = base_len_ff;
         decl_c  = ent_decl_ff;
         ext_c   = ext_len_ff;
         seen_c  = ent_seen_ff;
         pos_c   = ent_pos_ff;
         kind_c  = ent_kind_ff;
         cpu_c   = cpu_cnt_ff;
      end
      active = item.first || (phase_ff == PH_BASE) || (phase_ff == PH_EXT);

      if (step && active) begin
         sum_new = sum_c + b;

         if (phase_c == PH_EXT) begin
            // Extended table: only the end check
            if (({1'b0, off_c} + 18'd1) == ({2'b00, base_c} + {2'b00, ext_c})) begin
               fin    = 1'b1;
               fin_st = (sum_new != 8'd0) ? ST_EXT_SUM : ST_OK;
            end
         end else begin
            // Header fields, then the entry walk
            priority if (off_c < OFF_SIG_END) begin
               if (b != sig_byte(off_c[1:0])) begin
                  fin    = 1'b1;
                  fin_st = ST_BAD_SIG;
               end
            end else if (off_c == OFF_BASE_LO) begin
               base_c = {8'd0, b};
            end else if (off_c == OFF_BASE_HI) begin
               base_c = {b, base_c[7:0]};
               if (base_c < HDR_LEN_MIN) begin
                  fin    = 1'b1;
                  fin_st = ST_SHORT;
               end
            end else if (off_c == OFF_CNT_LO) begin
               decl_c = {8'd0, b};
            end else if (off_c == OFF_CNT_HI) begin
               decl_c = {b, decl_c[7:0]};
            end else if (off_c == OFF_EXT_LO) begin
               ext_c = {8'd0, b};
            end else if (off_c == OFF_EXT_HI) begin
               ext_c = {b, ext_c[7:0]};
            end else if (off_c >= HDR_BYTES && seen_c < decl_c) begin
               if (pos_c == 5'd0) begin
                  kind_c = b;
               end
               size_c = (kind_c == KIND_PROC) ? PROC_ENTRY_BYTES : OTHER_ENTRY_BYTES;
               if (pos_c == 5'd1 && kind_c == KIND_PROC) begin
                  report = 1'b1;
                  rep_id = b;
               end
               pos_next = pos_c + 5'd1;
               if (pos_next >= size_c) begin
                  pos_c  = '0;
                  seen_c = seen_c + 16'd1;
               end else begin
                  pos_c = pos_next;
               end
            end else begin
            end

            // End of base table
            if (!fin && off_c >= HDR_LAST
                && ({1'b0, off_c} + 18'd1) == {2'b00, base_c}) begin
               if (sum_new != 8'd0) begin
                  fin    = 1'b1;
                  fin_st = ST_BASE_SUM;
               end else if (ext_c == 16'd0) begin
                  fin    = 1'b1;
                  fin_st = ST_OK;
               end else begin
                  phase_c = PH_EXT;
                  sum_new = '0;
               end
            end
         end

         phase_in    = phase_c;
         offset_in   = off_c + 17'd1;
         sum_in      = sum_new;
         base_len_in = base_c;
         ent_decl_in = decl_c;
         ext_len_in  = ext_c;
         ent_seen_in = seen_c;
         ent_pos_in  = pos_c;
         ent_kind_in = kind_c;
         cpu_cnt_in  = cpu_c;

         // Final result wins over a processor report
         if (fin) begin
            phase_in      = PH_DONE;
            res_valid     = 1'b1;
            res.is_done   = 1'b1;
            res.apic_id   = '0;
            res.status    = fin_st;
            res.cpu_count = cpu_c;
         end else if (report) begin
            if (cpu_c != CPU_COUNT_MAX) begin
               cpu_cnt_in = cpu_c + 8'd1;
            end
            res_valid     = 1'b1;
            res.is_done   = 1'b0;
            res.apic_id   = rep_id;
            res.status    = ST_OK;
            res.cpu_count = cpu_cnt_in;
         end
      end
   end

   // Hold parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         offset_ff   <= '0;
         sum_ff      <= '0;
         base_len_ff <= '0;
         ent_decl_ff <= '0;
         ext_len_ff  <= '0;
         ent_seen_ff <= '0;
         ent_pos_ff  <= '0;
         ent_kind_ff <= '0;
         cpu_cnt_ff  <= '0;
      end else begin
         phase_ff    <= phase_in;
         offset_ff   <= offset_in;
         sum_ff      <= sum_in;
         base_len_ff <= base_len_in;
         ent_decl_ff <= ent_decl_in;
         ext_len_ff  <= ext_len_in;
         ent_seen_ff <= ent_seen_in;
         ent_pos_ff  <= ent_pos_in;
         ent_kind_ff <= ent_kind_in;
         cpu_cnt_ff  <= cpu_cnt_in;
      end
   end

endmodule

`default_nettype wire

[sv/mp_config_table_parser_top.sv]
// Top level of the MP configuration table parser: input register, parser, result register.
//
// Usage:
//   The req_ channel carries one table byte per transfer (data_byte) with a
//   first mark that starts a new table; a first byte restarts the parse at
//   any time. Bytes without first are dropped while no table is open.
//   The rsp_ channel carries zero or one result per byte: a processor report
//   (is_done = 0, apic_id, running cpu_count) on the APIC id byte of each
//   processor entry, or a final result (is_done = 1, status, cpu_count).
//   Path: a result is registered; its byte passes the input register, then
//   the parse logic, then the result register.
//   Throughput: one byte per cycle while the result slot is free or being
//   emptied; the parse state updates in one pass of logic between the registers.
//   Stall: when rsp_ready is low and a result is waiting, the byte in the
//   input register holds and req_ready falls; it rises again as soon as the
//   result is taken. Bytes that give no result still need a free result slot.
//   Reset: synchronous, active high; clears the valid bits of both registers
//   and returns the parser to idle with all counters zero.
`default_nettype none

module mp_config_table_parser_top
   import mpct_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    step;
   logic    res_valid;
   rsp_type res;

   // Advance the input byte when the result slot is free or being emptied
   assign step      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   mpct_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (in_data_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (step) begin
         rsp_valid_in = res_valid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (step && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // A processor report always carries status ok and a nonzero count
   a_report_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.is_done) |-> (rsp_data.status == ST_OK
                                            && rsp_data.cpu_count != 8'd0))
      else $error("processor report with bad status or zero count");

   // A final result carries no APIC id
   a_final_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.is_done) |-> (rsp_data.apic_id == 8'd0))
      else $error("final result with nonzero apic id");

   // Input stalls only behind a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && rsp_valid && !rsp_ready))
      else $error("input stalled without a blocked result");

   // A byte waiting behind a blocked result is still there next cycle
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid && !rsp_ready) |=> in_valid_ff)
      else $error("input byte lost while result stalled");
`endif

endmodule

`default_nettype wire
